@@ rtl/core/mtep_pkg.sv @@
// Shared types and constants of the MIDI track event parser.
package mtep_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;

    localparam int BYTE_W = 8;
    localparam int DATA_W = 7;
    localparam int TICK_W = 32;
    localparam int LEN_W  = 28;
    localparam int CNT_W  = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map, as word indexes.
    localparam logic REG_TRACK_LENGTH = 1'b0;

    localparam logic [BYTE_W-1:0] META_STATUS    = 8'hFF;
    localparam logic [BYTE_W-1:0] END_OF_TRACK   = 8'h2F;
    localparam logic [BYTE_W-1:0] SYSTEM_STATUS  = 8'hF0;
    localparam logic [3:0]        PROGRAM_CHANGE = 4'hC;
    localparam logic [3:0]        CHAN_PRESSURE  = 4'hD;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_MLEN,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CHANNEL      = 3'd0,
        KIND_META_HEADER  = 3'd1,
        KIND_META_PAYLOAD = 3'd2,
        KIND_END_TRACK    = 3'd3,
        KIND_ERROR        = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [TICK_W-1:0] tick;
        logic [BYTE_W-1:0] code;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  mlen;
        logic [BYTE_W-1:0] payload;
        logic              last;
    } result_t;

endpackage

@@ rtl/core/mtep_apb_regs.sv @@
// APB configuration register holding the track length.
module mtep_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mtep_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mtep_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mtep_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [mtep_pkg::TICK_W-1:0]       track_length
);

    logic [mtep_pkg::TICK_W-1:0] length_reg;
    logic                        sel_length;

    // The low two address bits select a byte within the word and are ignored.
    assign sel_length = (paddr[2] == mtep_pkg::REG_TRACK_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (psel && penable && pwrite && sel_length)
        begin
            length_reg <= pwdata;
        end
    end

    assign prdata       = sel_length ? length_reg : '0;
    assign pready       = 1'b1;
    assign track_length = length_reg;

endmodule

@@ rtl/core/mtep_in_stage.sv @@
// Input register that holds one track byte for the decoder.
module mtep_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [mtep_pkg::BYTE_W-1:0]   in_byte,
    output logic                          in_ready,
    input  logic                          take,
    output logic                          beat_valid,
    output logic [mtep_pkg::BYTE_W-1:0]   beat_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [mtep_pkg::BYTE_W-1:0] byte_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign beat_valid = valid_reg;
    assign beat_byte  = byte_reg;

endmodule

@@ rtl/core/mtep_decoder.sv @@
// Parser state and the per-byte decode of delta times, channel and meta events.
module mtep_decoder #(
    parameter int MAX_LENGTH_BYTES = mtep_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [mtep_pkg::BYTE_W-1:0]   beat_byte,
    input  logic [mtep_pkg::TICK_W-1:0]   track_length,
    output logic                          res_valid,
    output mtep_pkg::result_t             res
);

    localparam int LBC_W = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;

    mtep_pkg::phase_t            phase_reg,    phase_next;
    logic [mtep_pkg::BYTE_W-1:0] status_reg,   status_next;
    logic [mtep_pkg::TICK_W-1:0] tick_reg,     tick_next;
    logic [mtep_pkg::LEN_W-1:0]  acc_reg,      acc_next;
    logic [LBC_W-1:0]            lcnt_reg,     lcnt_next;
    logic [mtep_pkg::BYTE_W-1:0] mtype_reg,    mtype_next;
    logic [mtep_pkg::LEN_W-1:0]  remain_reg,   remain_next;
    logic [mtep_pkg::DATA_W-1:0] held_reg,     held_next;
    logic [mtep_pkg::TICK_W-1:0] consumed_reg, consumed_next;

    logic                        beyond;
    logic                        clear_all;
    logic [mtep_pkg::LEN_W-1:0]  acc_new;
    logic                        len_cont;
    logic                        len_over;
    logic                        one_byte;
    logic                        is_system;
    logic [mtep_pkg::LEN_W-1:0]  remain_dec;

    assign beyond     = (consumed_reg >= track_length);
    assign acc_new    = {acc_reg[mtep_pkg::LEN_W-mtep_pkg::DATA_W-1:0],
                         beat_byte[mtep_pkg::DATA_W-1:0]};
    assign len_cont   = beat_byte[7];
    assign len_over   = len_cont &&
                        (({1'b0, lcnt_reg} + (LBC_W+1)'(1)) >= (LBC_W+1)'(MAX_LENGTH_BYTES));
    assign one_byte   = (status_reg[7:4] == mtep_pkg::PROGRAM_CHANGE) ||
                        (status_reg[7:4] == mtep_pkg::CHAN_PRESSURE);
    assign is_system  = (beat_byte >= mtep_pkg::SYSTEM_STATUS);
    assign remain_dec = remain_reg - mtep_pkg::LEN_W'(1);

    // Next state.
    always_comb
    begin
        phase_next    = phase_reg;
        status_next   = status_reg;
        tick_next     = tick_reg;
        acc_next      = acc_reg;
        lcnt_next     = lcnt_reg;
        mtype_next    = mtype_reg;
        remain_next   = remain_reg;
        held_next     = held_reg;
        consumed_next = consumed_reg;
        clear_all     = 1'b0;

        if (step)
        begin
            if (beyond)
            begin
                clear_all = 1'b1;
            end
            else
            begin
                consumed_next = consumed_reg + mtep_pkg::TICK_W'(1);
                unique case (phase_reg)
                    mtep_pkg::PH_STATUS:
                    begin
                        if (beat_byte == mtep_pkg::META_STATUS)
                        begin
                            phase_next = mtep_pkg::PH_MTYPE;
                        end
                        else if (is_system)
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                            acc_next   = '0;
                            lcnt_next  = '0;
                        end
                        else if (beat_byte[7])
                        begin
                            status_next = beat_byte;
                            phase_next  = mtep_pkg::PH_DATA1;
                        end
                        else if (status_reg == '0)
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                            acc_next   = '0;
                            lcnt_next  = '0;
                        end
                        else if (one_byte)
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                        end
                        else
                        begin
                            held_next  = beat_byte[mtep_pkg::DATA_W-1:0];
                            phase_next = mtep_pkg::PH_DATA2;
                        end
                    end
                    mtep_pkg::PH_DATA1:
                    begin
                        if (one_byte)
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                        end
                        else
                        begin
                            held_next  = beat_byte[mtep_pkg::DATA_W-1:0];
                            phase_next = mtep_pkg::PH_DATA2;
                        end
                    end
                    mtep_pkg::PH_DATA2:
                    begin
                        phase_next = mtep_pkg::PH_DELTA;
                    end
                    mtep_pkg::PH_MTYPE:
                    begin
                        mtype_next = beat_byte;
                        acc_next   = '0;
                        lcnt_next  = '0;
                        phase_next = mtep_pkg::PH_MLEN;
                    end
                    mtep_pkg::PH_MLEN:
                    begin
                        acc_next = acc_new;
                        if (len_over)
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                            acc_next   = '0;
                            lcnt_next  = '0;
                        end
                        else if (len_cont)
                        begin
                            lcnt_next = lcnt_reg + LBC_W'(1);
                        end
                        else if (mtype_reg == mtep_pkg::END_OF_TRACK)
                        begin
                            clear_all = 1'b1;
                        end
                        else
                        begin
                            remain_next = acc_new;
                            acc_next    = '0;
                            lcnt_next   = '0;
                            phase_next  = (acc_new == '0) ? mtep_pkg::PH_DELTA
                                                          : mtep_pkg::PH_PAYLOAD;
                        end
                    end
                    mtep_pkg::PH_PAYLOAD:
                    begin
                        remain_next = remain_dec;
                        if (remain_dec == '0)
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                        end
                    end
                    default:
                    begin
                        // Delta time: a variable-length quantity added to the tick.
                        acc_next = acc_new;
                        if (len_over)
                        begin
                            phase_next = mtep_pkg::PH_DELTA;
                            acc_next   = '0;
                            lcnt_next  = '0;
                        end
                        else if (len_cont)
                        begin
                            lcnt_next = lcnt_reg + LBC_W'(1);
                        end
                        else
                        begin
                            tick_next  = tick_reg + {4'b0000, acc_new};
                            acc_next   = '0;
                            lcnt_next  = '0;
                            phase_next = mtep_pkg::PH_STATUS;
                        end
                    end
                endcase
            end

            if (clear_all)
            begin
                phase_next    = mtep_pkg::PH_DELTA;
                status_next   = '0;
                tick_next     = '0;
                acc_next      = '0;
                lcnt_next     = '0;
                mtype_next    = '0;
                remain_next   = '0;
                held_next     = '0;
                consumed_next = '0;
            end
        end
    end

    // Result of the current beat; the tick is the sum before this beat.
    always_comb
    begin
        res_valid   = 1'b0;
        res         = '0;
        res.tick    = tick_reg;
        res.kind    = mtep_pkg::KIND_ERROR;
        res.last    = 1'b1;

        if (step)
        begin
            if (beyond)
            begin
                res_valid = 1'b1;
                res.kind  = mtep_pkg::KIND_END_TRACK;
                res.code  = mtep_pkg::END_OF_TRACK;
            end
            else
            begin
                unique case (phase_reg)
                    mtep_pkg::PH_STATUS:
                    begin
                        if (beat_byte != mtep_pkg::META_STATUS && is_system)
                        begin
                            res_valid = 1'b1;
                        end
                        else if (!beat_byte[7] && status_reg == '0)
                        begin
                            res_valid = 1'b1;
                        end
                        else if (!beat_byte[7] && one_byte)
                        begin
                            res_valid = 1'b1;
                            res.kind  = mtep_pkg::KIND_CHANNEL;
                            res.code  = status_reg;
                            res.first = beat_byte[mtep_pkg::DATA_W-1:0];
                            res.count = mtep_pkg::CNT_W'(1);
                        end
                    end
                    mtep_pkg::PH_DATA1:
                    begin
                        if (one_byte)
                        begin
                            res_valid = 1'b1;
                            res.kind  = mtep_pkg::KIND_CHANNEL;
                            res.code  = status_reg;
                            res.first = beat_byte[mtep_pkg::DATA_W-1:0];
                            res.count = mtep_pkg::CNT_W'(1);
                        end
                    end
                    mtep_pkg::PH_DATA2:
                    begin
                        res_valid  = 1'b1;
                        res.kind   = mtep_pkg::KIND_CHANNEL;
                        res.code   = status_reg;
                        res.first  = held_reg;
                        res.second = beat_byte[mtep_pkg::DATA_W-1:0];
                        res.count  = mtep_pkg::CNT_W'(2);
                    end
                    mtep_pkg::PH_MTYPE:
                    begin
                        res_valid = 1'b0;
                    end
                    mtep_pkg::PH_MLEN:
                    begin
                        if (len_over)
                        begin
                            res_valid = 1'b1;
                        end
                        else if (!len_cont)
                        begin
                            res_valid = 1'b1;
                            res.mlen  = acc_new;
                            if (mtype_reg == mtep_pkg::END_OF_TRACK)
                            begin
                                res.kind = mtep_pkg::KIND_END_TRACK;
                                res.code = mtep_pkg::END_OF_TRACK;
                            end
                            else
                            begin
                                res.kind = mtep_pkg::KIND_META_HEADER;
                                res.code = mtype_reg;
                                res.last = (acc_new == '0);
                            end
                        end
                    end
                    mtep_pkg::PH_PAYLOAD:
                    begin
                        res_valid   = 1'b1;
                        res.kind    = mtep_pkg::KIND_META_PAYLOAD;
                        res.code    = mtype_reg;
                        res.payload = beat_byte;
                        res.last    = (remain_dec == '0);
                    end
                    default:
                    begin
                        res_valid = len_over;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mtep_pkg::PH_DELTA;
            status_reg   <= '0;
            tick_reg     <= '0;
            acc_reg      <= '0;
            lcnt_reg     <= '0;
            mtype_reg    <= '0;
            remain_reg   <= '0;
            held_reg     <= '0;
            consumed_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            status_reg   <= status_next;
            tick_reg     <= tick_next;
            acc_reg      <= acc_next;
            lcnt_reg     <= lcnt_next;
            mtype_reg    <= mtype_next;
            remain_reg   <= remain_next;
            held_reg     <= held_next;
            consumed_reg <= consumed_next;
        end
    end

endmodule

@@ rtl/core/mtep_out_stage.sv @@
// Result register toward the consumer.
module mtep_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mtep_pkg::result_t res_in,
    input  logic              out_ready,
    output logic              can_take,
    output logic              out_valid,
    output mtep_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    mtep_pkg::result_t res_reg;

    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

@@ rtl/core/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser.
//
//   channel   direction  handshake                       payload
//   track     in         track_valid / track_ready       track_byte
//   result    out        result_valid / result_ready     result_kind .. last_of_event
//   config    in         APB psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One track byte is taken per cycle while the result register can take one; its result,
// if any, is loaded into the result register at the edge that accepts its beat (input
// register, then decode into the result register).
// The decode is one pass of next-state logic over the parser state.
// Reset clears the parser state, the valid flags and track_length.
// A stalled result holds the result register; the input register then fills and
// track_ready drops until the consumer takes the beat.
module midi_track_event_parser #(
    parameter int MAX_LENGTH_BYTES = mtep_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            track_valid,
    output logic                            track_ready,
    input  logic [7:0]                      track_byte,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [2:0]                      result_kind,
    output logic [31:0]                     tick_time,
    output logic [7:0]                      event_code,
    output logic [6:0]                      first_data,
    output logic [6:0]                      second_data,
    output logic [1:0]                      data_count,
    output logic [27:0]                     meta_length,
    output logic [7:0]                      payload_byte,
    output logic                            last_of_event,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtep_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mtep_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mtep_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic                        beat_valid;
    logic [mtep_pkg::BYTE_W-1:0] beat_byte;
    logic                        can_take;
    logic                        step;
    logic                        res_valid;
    mtep_pkg::result_t           res;
    mtep_pkg::result_t           res_out;
    logic [mtep_pkg::TICK_W-1:0] track_length;

    assign step = beat_valid && can_take;

    mtep_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .track_length (track_length)
    );

    mtep_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (track_valid),
        .in_byte    (track_byte),
        .in_ready   (track_ready),
        .take       (step),
        .beat_valid (beat_valid),
        .beat_byte  (beat_byte)
    );

    mtep_decoder #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_dec (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .beat_byte    (beat_byte),
        .track_length (track_length),
        .res_valid    (res_valid),
        .res          (res)
    );

    mtep_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res_in    (res),
        .out_ready (result_ready),
        .can_take  (can_take),
        .out_valid (result_valid),
        .res_out   (res_out)
    );

    assign result_kind   = res_out.kind;
    assign tick_time     = res_out.tick;
    assign event_code    = res_out.code;
    assign first_data    = res_out.first;
    assign second_data   = res_out.second;
    assign data_count    = res_out.count;
    assign meta_length   = res_out.mlen;
    assign payload_byte  = res_out.payload;
    assign last_of_event = res_out.last;

endmodule

@@ rtl/core/mtep_checker.sv @@
// Port-level checks of the MIDI track event parser, bound to the top level.
module mtep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [2:0]  result_kind,
    input logic [7:0]  event_code,
    input logic [1:0]  data_count,
    input logic [6:0]  second_data,
    input logic        last_of_event
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_kind))
        else $error("result beat changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_kind <= mtep_pkg::KIND_ERROR)
        else $error("result kind out of range");

    a_channel_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == mtep_pkg::KIND_CHANNEL |->
            data_count != 2'd0 && data_count != 2'd3 && last_of_event &&
            (data_count == 2'd2 || second_data == 7'd0))
        else $error("channel event with bad data count");

    a_end_track: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == mtep_pkg::KIND_END_TRACK |->
            event_code == mtep_pkg::END_OF_TRACK && last_of_event)
        else $error("end of track not marked as last");

    a_non_channel_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind != mtep_pkg::KIND_CHANNEL |-> data_count == 2'd0)
        else $error("data count set outside a channel event");

endmodule

bind midi_track_event_parser mtep_checker u_checker (.*);

@@ tb/track_event_checker.sv @@
// Checker for the MIDI track event parser: predicts each result from accepted beats.
module track_event_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            track_valid,
    input  logic                            track_ready,
    input  logic [7:0]                      track_byte,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  logic [2:0]                      result_kind,
    input  logic [31:0]                     tick_time,
    input  logic [7:0]                      event_code,
    input  logic [6:0]                      first_data,
    input  logic [6:0]                      second_data,
    input  logic [1:0]                      data_count,
    input  logic [27:0]                     meta_length,
    input  logic [7:0]                      payload_byte,
    input  logic                            last_of_event,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtep_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mtep_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [mtep_pkg::APB_DATA_W-1:0] prdata,
    input  logic                            pready,
    output int                              errors,
    output int                              pending
);

    localparam int MAX_LEN_BYTES = mtep_pkg::MAX_LENGTH_BYTES_DEF;

    typedef enum int {
        LEN_MORE,
        LEN_DONE,
        LEN_TOO_LONG
    } len_step_t;

    mtep_pkg::phase_t  phase;
    logic [7:0]        run_status;
    logic [31:0]       tick_sum;
    logic [27:0]       len_acc;
    logic [2:0]        len_count;
    logic [7:0]        meta_type;
    logic [27:0]       payload_left;
    logic [6:0]        held_first;
    logic [31:0]       consumed;
    logic [31:0]       track_len;
    mtep_pkg::result_t expected_events[$];

    function automatic void restart_track();
        phase        = mtep_pkg::PH_DELTA;
        run_status   = '0;
        tick_sum     = '0;
        len_acc      = '0;
        len_count    = '0;
        meta_type    = '0;
        payload_left = '0;
        held_first   = '0;
        consumed     = '0;
    endfunction

    // Shifts one byte of a variable-length quantity into the accumulator.
    function automatic len_step_t shift_length(input logic [7:0] b);
        len_acc = {len_acc[20:0], b[6:0]};
        if (!b[7])
            return LEN_DONE;
        if (int'(len_count) + 1 >= MAX_LEN_BYTES)
            return LEN_TOO_LONG;
        len_count++;
        return LEN_MORE;
    endfunction

    function automatic bit decode_track_byte(input logic [7:0] b,
                                             output mtep_pkg::result_t r);
        len_step_t step;
        bit        as_first;
        bit        fault;
        r        = '0;
        r.tick   = tick_sum;
        r.last   = 1'b1;
        as_first = 1'b0;
        fault    = 1'b0;
        // Bytes past the chunk length are dropped and close the track.
        if (consumed >= track_len)
        begin
            r.kind = mtep_pkg::KIND_END_TRACK;
            r.code = mtep_pkg::END_OF_TRACK;
            restart_track();
            return 1'b1;
        end
        consumed++;
        case (phase)
            mtep_pkg::PH_STATUS:
            begin
                if (b == mtep_pkg::META_STATUS)
                begin
                    phase = mtep_pkg::PH_MTYPE;
                    return 1'b0;
                end
                if (b >= mtep_pkg::SYSTEM_STATUS)
                    fault = 1'b1;
                else if (b[7])
                begin
                    run_status = b;
                    phase      = mtep_pkg::PH_DATA1;
                    return 1'b0;
                end
                else if (run_status == '0)
                    fault = 1'b1;
                else
                    as_first = 1'b1;
            end
            mtep_pkg::PH_DATA1:
                as_first = 1'b1;
            mtep_pkg::PH_DATA2:
            begin
                phase    = mtep_pkg::PH_DELTA;
                r.kind   = mtep_pkg::KIND_CHANNEL;
                r.code   = run_status;
                r.first  = held_first;
                r.second = b[6:0];
                r.count  = 2'd2;
                return 1'b1;
            end
            mtep_pkg::PH_MTYPE:
            begin
                meta_type = b;
                len_acc   = '0;
                len_count = '0;
                phase     = mtep_pkg::PH_MLEN;
                return 1'b0;
            end
            mtep_pkg::PH_MLEN:
            begin
                step = shift_length(b);
                if (step == LEN_MORE)
                    return 1'b0;
                if (step == LEN_TOO_LONG)
                    fault = 1'b1;
                else if (meta_type == mtep_pkg::END_OF_TRACK)
                begin
                    r.kind = mtep_pkg::KIND_END_TRACK;
                    r.code = mtep_pkg::END_OF_TRACK;
                    r.mlen = len_acc;
                    restart_track();
                    return 1'b1;
                end
                else
                begin
                    payload_left = len_acc;
                    len_acc      = '0;
                    len_count    = '0;
                    phase        = (payload_left == '0) ? mtep_pkg::PH_DELTA
                                                        : mtep_pkg::PH_PAYLOAD;
                    r.kind       = mtep_pkg::KIND_META_HEADER;
                    r.code       = meta_type;
                    r.mlen       = payload_left;
                    r.last       = (payload_left == '0);
                    return 1'b1;
                end
            end
            mtep_pkg::PH_PAYLOAD:
            begin
                payload_left = payload_left - 28'd1;
                if (payload_left == '0)
                    phase = mtep_pkg::PH_DELTA;
                r.kind    = mtep_pkg::KIND_META_PAYLOAD;
                r.code    = meta_type;
                r.payload = b;
                r.last    = (payload_left == '0);
                return 1'b1;
            end
            default:
            begin
                step = shift_length(b);
                if (step == LEN_MORE)
                    return 1'b0;
                if (step == LEN_TOO_LONG)
                    fault = 1'b1;
                else
                begin
                    tick_sum  = tick_sum + {4'b0000, len_acc};
                    len_acc   = '0;
                    len_count = '0;
                    phase     = mtep_pkg::PH_STATUS;
                    return 1'b0;
                end
            end
        endcase
        if (fault)
        begin
            phase     = mtep_pkg::PH_DELTA;
            len_acc   = '0;
            len_count = '0;
            r.kind    = mtep_pkg::KIND_ERROR;
            return 1'b1;
        end
        // The byte is the first data byte of a channel event.
        if (run_status[7:4] == mtep_pkg::PROGRAM_CHANGE ||
            run_status[7:4] == mtep_pkg::CHAN_PRESSURE)
        begin
            phase   = mtep_pkg::PH_DELTA;
            r.kind  = mtep_pkg::KIND_CHANNEL;
            r.code  = run_status;
            r.first = b[6:0];
            r.count = 2'd1;
            return 1'b1;
        end
        held_first = b[6:0];
        phase      = mtep_pkg::PH_DATA2;
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mtep_pkg::result_t want;
        mtep_pkg::result_t fresh;
        if (!rst_n)
        begin
            restart_track();
            track_len = '0;
            expected_events.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual kind %0d code 0x%0h",
                             $time, result_kind, event_code);
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(result_kind));
                    check_field("tick_time", want.tick, tick_time);
                    check_field("event_code", 32'(want.code), 32'(event_code));
                    check_field("first_data", 32'(want.first), 32'(first_data));
                    check_field("second_data", 32'(want.second), 32'(second_data));
                    check_field("data_count", 32'(want.count), 32'(data_count));
                    check_field("meta_length", 32'(want.mlen), 32'(meta_length));
                    check_field("payload_byte", 32'(want.payload), 32'(payload_byte));
                    check_field("last_of_event", 32'(want.last), 32'(last_of_event));
                end
            end
            if (track_valid && track_ready)
            begin
                if (decode_track_byte(track_byte, fresh))
                    expected_events.push_back(fresh);
            end
            if (psel && penable && pready &&
                paddr[mtep_pkg::APB_ADDR_W-1:2] == mtep_pkg::REG_TRACK_LENGTH)
            begin
                if (pwrite)
                    track_len = pwdata;
                else
                    check_field("prdata", track_len, prdata);
            end
            pending <= expected_events.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the MIDI track event parser testbench: clock, reset, stimulus and verdict.
module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [mtep_pkg::APB_ADDR_W-1:0] TRACK_LENGTH_ADDR =
        {mtep_pkg::REG_TRACK_LENGTH, 2'b00};
    localparam logic [mtep_pkg::APB_ADDR_W-1:0] SPARE_ADDR =
        {~mtep_pkg::REG_TRACK_LENGTH, 2'b00};
    localparam logic [31:0] LONGEST_TRACK = 32'hFFFF_FFFF;

    localparam logic [3:0] NOTE_OFF   = 4'h8;
    localparam logic [3:0] NOTE_ON    = 4'h9;
    localparam logic [3:0] PITCH_BEND = 4'hE;
    localparam logic [7:0] SYSEX_END  = 8'hF7;
    localparam logic [7:0] TEXT_META  = 8'h01;

    logic                            clk;
    logic                            rst_n;
    logic                            track_valid;
    logic                            track_ready;
    logic [7:0]                      track_byte;
    logic                            result_valid;
    logic                            result_ready;
    logic [2:0]                      result_kind;
    logic [31:0]                     tick_time;
    logic [7:0]                      event_code;
    logic [6:0]                      first_data;
    logic [6:0]                      second_data;
    logic [1:0]                      data_count;
    logic [27:0]                     meta_length;
    logic [7:0]                      payload_byte;
    logic                            last_of_event;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mtep_pkg::APB_ADDR_W-1:0] paddr;
    logic [mtep_pkg::APB_DATA_W-1:0] pwdata;
    logic [mtep_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int          check_errors;
    int          pending;
    int          cycle_count   = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int          sink_hold     = 0;
    logic [7:0]  track_bytes[$];
    logic [7:0]  gen_status;
    bit          have_status;

    midi_track_event_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .track_valid   (track_valid),
        .track_ready   (track_ready),
        .track_byte    (track_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_kind   (result_kind),
        .tick_time     (tick_time),
        .event_code    (event_code),
        .first_data    (first_data),
        .second_data   (second_data),
        .data_count    (data_count),
        .meta_length   (meta_length),
        .payload_byte  (payload_byte),
        .last_of_event (last_of_event),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    track_event_checker event_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .track_valid   (track_valid),
        .track_ready   (track_ready),
        .track_byte    (track_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_kind   (result_kind),
        .tick_time     (tick_time),
        .event_code    (event_code),
        .first_data    (first_data),
        .second_data   (second_data),
        .data_count    (data_count),
        .meta_length   (meta_length),
        .payload_byte  (payload_byte),
        .last_of_event (last_of_event),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (check_errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** midi_track_event_parser: FAILED **");
            $finish;
        end
    end

    // Result side back-pressure, in bursts.
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold--;
            if (sink_hold == 0)
                result_ready <= 1'b1;
        end
        else if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct)
        begin
            sink_hold = $urandom_range(1, 12);
            result_ready <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        @(negedge clk);
        if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct)
        begin
            track_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        track_valid <= 1'b1;
        track_byte  <= value;
        do @(posedge clk); while (!track_ready);
    endtask

    task automatic send_queued();
        while (track_bytes.size() != 0)
            send_byte(track_bytes.pop_front());
        @(negedge clk);
        track_valid <= 1'b0;
    endtask

    // Waits until every predicted result is out and in-flight bytes have left the pipe.
    task automatic settle();
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input bit is_write,
                                input logic [mtep_pkg::APB_ADDR_W-1:0] addr,
                                input logic [mtep_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_track_length(input logic [31:0] value);
        apb_transfer(1'b1, TRACK_LENGTH_ADDR, value);
        apb_transfer(1'b0, TRACK_LENGTH_ADDR, '0);
    endtask

    // Variable-length quantity, sometimes padded with leading zero groups.
    function automatic void add_length(input logic [27:0] value);
        int groups;
        int i;
        groups = 1;
        while (groups < 4 && (value >> (7 * groups)) != 0)
            groups++;
        if ($urandom_range(0, 7) == 0)
            groups = int'($urandom_range(groups, 4));
        for (i = groups - 1; i >= 0; i--)
            track_bytes.push_back({i != 0, value[7 * i +: 7]});
    endfunction

    function automatic void add_overlong();
        int i;
        for (i = 0; i < mtep_pkg::MAX_LENGTH_BYTES_DEF; i++)
            track_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
    endfunction

    function automatic void add_delta(input int big_pct);
        int pick;
        pick = $urandom_range(1, 100);
        if ($urandom_range(0, 39) == 0)
            add_overlong();
        if (pick <= big_pct)
            add_length(28'($urandom_range(32'h0FFF_FFFF, 32'h0F00_0000)));
        else if (pick <= big_pct + 20)
            add_length(28'($urandom_range(16383, 128)));
        else
            add_length(28'($urandom_range(127, 0)));
    endfunction

    function automatic void add_channel_event();
        logic [3:0] kind_nib;
        logic [3:0] chan;
        bit         running;
        int         n;
        int         i;
        running = have_status && $urandom_range(0, 2) == 0;
        if (!running)
        begin
            kind_nib   = 4'($urandom_range(PITCH_BEND, NOTE_OFF));
            chan       = 4'($urandom_range(15, 0));
            gen_status = {kind_nib, chan};
            have_status = 1'b1;
            track_bytes.push_back(gen_status);
        end
        n = (gen_status[7:4] == mtep_pkg::PROGRAM_CHANGE ||
             gen_status[7:4] == mtep_pkg::CHAN_PRESSURE) ? 1 : 2;
        for (i = 0; i < n; i++)
        begin
            // A running-status event must open with a clean data byte.
            if ((running && i == 0) || $urandom_range(0, 15) != 0)
                track_bytes.push_back(8'($urandom_range(127, 0)));
            else
                track_bytes.push_back(8'($urandom_range(255, 0)));
        end
    endfunction

    function automatic void add_meta_event();
        int len;
        int i;
        track_bytes.push_back(mtep_pkg::META_STATUS);
        track_bytes.push_back(8'($urandom_range(255, 0)));
        if ($urandom_range(0, 19) == 0)
            add_overlong();
        else
        begin
            len = int'($urandom_range(6, 0));
            add_length(28'(len));
            for (i = 0; i < len; i++)
                track_bytes.push_back(8'($urandom_range(255, 0)));
        end
    endfunction

    function automatic void add_event(input int big_pct, input int eot_pct);
        int pick;
        int n;
        add_delta(big_pct);
        pick = $urandom_range(1, 100);
        if (pick <= eot_pct)
        begin
            track_bytes.push_back(mtep_pkg::META_STATUS);
            track_bytes.push_back(mtep_pkg::END_OF_TRACK);
            // A non-empty end-of-track leaves its payload to start the next track.
            if ($urandom_range(0, 3) == 0)
                add_length(28'($urandom_range(3, 1)));
            else
                add_length(28'd0);
            have_status = 1'b0;
        end
        else if (pick <= 60)
            add_channel_event();
        else if (pick <= 85)
            add_meta_event();
        else if (pick <= 92)
            track_bytes.push_back(8'(mtep_pkg::SYSTEM_STATUS + $urandom_range(14, 0)));
        else
        begin
            n = $urandom_range(3, 1);
            repeat (n) track_bytes.push_back(8'($urandom_range(255, 0)));
        end
    endfunction

    task automatic run_phase(input int items, input logic [31:0] len, input int big_pct,
                             input int eot_pct, input bit calm);
        set_track_length(len);
        src_idle_pct  = calm ? 0 : $urandom_range(0, 3) * 8;
        sink_idle_pct = calm ? 0 : $urandom_range(0, 3) * 8;
        while (track_bytes.size() < items)
            add_event(big_pct, eot_pct);
        send_queued();
        settle();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        track_valid  = 1'b0;
        track_byte   = '0;
        result_ready = 1'b1;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        have_status  = 1'b0;
        gen_status   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // An empty chunk ends the track on every byte.
        set_track_length('0);
        track_bytes.push_back(8'h00);
        track_bytes.push_back(8'hFF);
        send_queued();
        settle();

        // A write to an unmapped word leaves the length register alone.
        apb_transfer(1'b1, SPARE_ADDR, 32'hA5A5_5A5A);
        apb_transfer(1'b0, TRACK_LENGTH_ADDR, '0);

        set_track_length(LONGEST_TRACK);
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        // Data byte with no status seen yet.
        track_bytes.push_back(8'h00);
        track_bytes.push_back(8'h40);
        // Two-byte delta, then a note on and a running-status repeat.
        track_bytes.push_back(8'h81);
        track_bytes.push_back(8'h00);
        track_bytes.push_back({NOTE_ON, 4'h0});
        track_bytes.push_back(8'h3C);
        track_bytes.push_back(8'h7F);
        track_bytes.push_back(8'h00);
        track_bytes.push_back(8'h3C);
        track_bytes.push_back(8'h00);
        // Program change with a data byte that has its top bit set.
        track_bytes.push_back(8'h00);
        track_bytes.push_back({mtep_pkg::PROGRAM_CHANGE, 4'hF});
        track_bytes.push_back(8'h90);
        track_bytes.push_back(8'h00);
        track_bytes.push_back(mtep_pkg::META_STATUS);
        track_bytes.push_back(TEXT_META);
        track_bytes.push_back(8'h01);
        track_bytes.push_back(8'h41);
        track_bytes.push_back(8'h00);
        track_bytes.push_back(SYSEX_END);
        add_overlong();
        track_bytes.push_back(8'h00);
        track_bytes.push_back(mtep_pkg::META_STATUS);
        track_bytes.push_back(mtep_pkg::END_OF_TRACK);
        track_bytes.push_back(8'h00);
        send_queued();
        settle();

        // Largest meta length, cut off by the end of a short chunk.
        set_track_length(32'd8);
        track_bytes.push_back(8'h00);
        track_bytes.push_back(mtep_pkg::META_STATUS);
        track_bytes.push_back(TEXT_META);
        track_bytes.push_back(8'hFF);
        track_bytes.push_back(8'hFF);
        track_bytes.push_back(8'hFF);
        track_bytes.push_back(8'h7F);
        track_bytes.push_back(8'h5A);
        track_bytes.push_back(8'hA5);
        send_queued();
        settle();

        run_phase(380, LONGEST_TRACK, 12, 2, 1'b0);
        run_phase(300, $urandom_range(120, 16), 10, 4, 1'b0);
        run_phase(60, 32'd1, 0, 4, 1'b0);
        run_phase(280, $urandom, 50, 1, 1'b0);
        run_phase(240, LONGEST_TRACK, 15, 3, 1'b1);

        if (check_errors == 0)
            $display("** midi_track_event_parser: PASSED **");
        else
            $display("** midi_track_event_parser: FAILED **");
        $finish;
    end

endmodule
